// ===== rtl/core/disparity_region_stats_assert.svh =====
`ifndef DISPARITY_REGION_STATS_ASSERT_SVH
`define DISPARITY_REGION_STATS_ASSERT_SVH

// same-cycle implication, masked while in reset
`define DRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("disparity_region_stats: same-cycle check failed");

// next-cycle implication, also checked across reset
`define DRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("disparity_region_stats: next-cycle check failed");

`endif

// ===== rtl/core/drs_pkg.sv =====
package drs_pkg;

  localparam int COORD_W    = 11;
  localparam int DISP_W     = 8;
  localparam int FIX_W      = 32;
  localparam int FOCAL_W    = 16;
  localparam int SUM_W      = 55;
  localparam int CNT_W      = 23;
  localparam int DIST_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_NUM_W  = 56;
  localparam int DIV_DEN_W  = 23;
  localparam int DIV_CNT_W  = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam int COORD_MAX_DEF = 2048;
  localparam logic [32:0] MAX_REGION_PIXELS_DEF = 33'd4194304;

  localparam logic [DISP_W-1:0] DISP_INVALID = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISPARITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_PX        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_NUMERATOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_A         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_B         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_C         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET    = 3'd6;

  typedef struct packed {
    logic                ok;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [DISP_W-1:0]   disparity;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [DISP_W-1:0]        min_disparity;
    logic [FOCAL_W-1:0]       focal_px;
    logic [FIX_W-1:0]         depth_numerator;
    logic signed [FIX_W-1:0]  plane_a;
    logic signed [FIX_W-1:0]  plane_b;
    logic signed [FIX_W-1:0]  plane_c;
    logic signed [FIX_W-1:0]  plane_offset;
  } cfg_t;

endpackage

// ===== rtl/core/drs_queue.sv =====
module drs_queue #(
  parameter int DEPTH = drs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  drs_pkg::item_t wr_data,
  output logic          full,
  input  logic          rd,
  output drs_pkg::item_t rd_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  drs_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   fill;

  assign full    = (fill == (PTR_W+1)'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PTR_W'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == PTR_W'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/drs_front.sv =====
module drs_front #(
  parameter int COORD_MAX = drs_pkg::COORD_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [drs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drs_pkg::FIX_W-1:0]      cfg_data,
  input  logic                           push,
  input  logic [drs_pkg::COORD_W-1:0]    row,
  input  logic [drs_pkg::COORD_W-1:0]    col,
  input  logic [drs_pkg::DISP_W-1:0]     disparity,
  input  logic                           last,
  output logic                           q_wr,
  output drs_pkg::item_t                 q_data,
  output drs_pkg::cfg_t                  cfg
);

  localparam logic [16:0] CMAX = 17'(COORD_MAX);

  logic in_range;

  assign in_range = ({6'b0, row} < CMAX) && ({6'b0, col} < CMAX);

  // count-full check needs the running count, so the back end does it
  assign q_wr             = push;
  assign q_data.ok        = (disparity > cfg.min_disparity) &&
                            (disparity != drs_pkg::DISP_INVALID) && in_range;
  assign q_data.row       = row;
  assign q_data.col       = col;
  assign q_data.disparity = disparity;
  assign q_data.last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_disparity   <= 8'd1;
      cfg.focal_px        <= 16'd1;
      cfg.depth_numerator <= '0;
      cfg.plane_a         <= '0;
      cfg.plane_b         <= '0;
      cfg.plane_c         <= '0;
      cfg.plane_offset    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        drs_pkg::REG_MIN_DISPARITY:   cfg.min_disparity   <= cfg_data[7:0];
        drs_pkg::REG_FOCAL_PX:        cfg.focal_px        <= cfg_data[15:0];
        drs_pkg::REG_DEPTH_NUMERATOR: cfg.depth_numerator <= cfg_data;
        drs_pkg::REG_PLANE_A:         cfg.plane_a         <= $signed(cfg_data);
        drs_pkg::REG_PLANE_B:         cfg.plane_b         <= $signed(cfg_data);
        drs_pkg::REG_PLANE_C:         cfg.plane_c         <= $signed(cfg_data);
        drs_pkg::REG_PLANE_OFFSET:    cfg.plane_offset    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/drs_div.sv =====
module drs_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [drs_pkg::DIV_NUM_W-1:0]   num,
  input  logic [drs_pkg::DIV_DEN_W-1:0]   den,
  output logic                            done,
  output logic [drs_pkg::DIV_NUM_W-1:0]   quot
);

  localparam int NW = drs_pkg::DIV_NUM_W;
  localparam int DW = drs_pkg::DIV_DEN_W;

  logic [DW-1:0]                   rem;
  logic [DW-1:0]                   dreg;
  logic [drs_pkg::DIV_CNT_W-1:0]   cnt;
  logic                            busy;
  logic [DW:0]                     trial;
  logic                            ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quot[NW-1]};
  assign ge    = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      quot <= {quot[NW-2:0], ge};
      rem  <= ge ? DW'(trial - {1'b0, dreg}) : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= drs_pkg::DIV_CNT_W'(NW-1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/drs_back.sv =====
module drs_back #(
  parameter logic [32:0] MAX_REGION_PIXELS = drs_pkg::MAX_REGION_PIXELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  drs_pkg::cfg_t                        cfg,
  input  logic                                 q_empty,
  input  drs_pkg::item_t                       q_data,
  output logic                                 q_rd,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 found,
  output logic [drs_pkg::FIX_W-1:0]            centroid_x,
  output logic [drs_pkg::FIX_W-1:0]            centroid_y,
  output logic [drs_pkg::FIX_W-1:0]            centroid_z,
  output logic [drs_pkg::FIX_W-1:0]            extent_x,
  output logic [drs_pkg::FIX_W-1:0]            extent_y,
  output logic [drs_pkg::FIX_W-1:0]            extent_z,
  output logic [drs_pkg::FIX_W-1:0]            front_x,
  output logic [drs_pkg::FIX_W-1:0]            front_y,
  output logic [drs_pkg::FIX_W-1:0]            front_z,
  output logic signed [drs_pkg::DIST_W-1:0]    plane_distance
);

  localparam int FW = drs_pkg::FIX_W;
  localparam int NW = drs_pkg::DIV_NUM_W;
  localparam int CW = drs_pkg::CNT_W;
  localparam logic [CW-1:0] CAP =
    (MAX_REGION_PIXELS < 33'h7FFFFF) ? MAX_REGION_PIXELS[CW-1:0] : {CW{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE, S_ZW, S_XS, S_XW, S_YS, S_YW, S_UPD,
    S_CXS, S_CXW, S_CYS, S_CYW, S_CZS, S_CZW,
    S_P0, S_P1, S_P2, S_P3, S_PF, S_EMIT
  } state_t;

  state_t                      state;
  drs_pkg::item_t              cur;
  logic [CW-1:0]               count;
  logic [drs_pkg::SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic [FW-1:0]               min_x, max_x, min_y, max_y, min_z, max_z;
  logic [FW-1:0]               nearest_x, nearest_y;
  logic [FW-1:0]               z, x, y;
  logic [FW-1:0]               cen_x, cen_y, cen_z;
  logic signed [64:0]          prod;
  logic signed [66:0]          acc;
  logic signed [66:0]          dsum;
  logic [drs_pkg::DIST_W-1:0]  plane_dist;
  logic                        out_valid;
  logic                        emit_load;

  logic                            div_start;
  logic [NW-1:0]                   div_num;
  logic [drs_pkg::DIV_DEN_W-1:0]   div_den;
  logic                            div_done;
  logic [NW-1:0]                   div_quot;
  logic [drs_pkg::FOCAL_W-1:0]     fden;
  logic [FW-1:0]                   div_sat;
  logic                            take;

  drs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign fden      = (cfg.focal_px == '0) ? 16'd1 : cfg.focal_px;
  assign div_sat   = (div_quot[NW-1:FW] != '0) ? {FW{1'b1}} : div_quot[FW-1:0];
  assign q_rd      = (state == S_IDLE) && !q_empty;
  assign take      = q_rd && q_data.ok && (count != CAP);
  assign empty     = !out_valid;
  assign dsum      = (acc >>> 30) + 67'(cfg.plane_offset);
  assign emit_load = (state == S_EMIT) && (!out_valid || pop);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_IDLE: begin
        div_start = take;
        div_num   = NW'(cfg.depth_numerator);
        div_den   = drs_pkg::DIV_DEN_W'(q_data.disparity);
      end
      S_XS: begin
        div_start = 1'b1;
        div_num   = NW'(cur.col) * NW'(z);
        div_den   = drs_pkg::DIV_DEN_W'(fden);
      end
      S_YS: begin
        div_start = 1'b1;
        div_num   = NW'(cur.row) * NW'(z);
        div_den   = drs_pkg::DIV_DEN_W'(fden);
      end
      S_CXS: begin
        div_start = 1'b1;
        div_num   = NW'(sum_x);
        div_den   = count;
      end
      S_CYS: begin
        div_start = 1'b1;
        div_num   = NW'(sum_y);
        div_den   = count;
      end
      S_CZS: begin
        div_start = 1'b1;
        div_num   = NW'(sum_z);
        div_den   = count;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      min_x     <= '0;
      max_x     <= '0;
      min_y     <= '0;
      max_y     <= '0;
      min_z     <= '0;
      max_z     <= '0;
      nearest_x <= '0;
      nearest_y <= '0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_rd) begin
            cur <= q_data;
            if (take) begin
              state <= S_ZW;
            end else if (q_data.last) begin
              state <= (count != '0) ? S_CXS : S_EMIT;
            end
          end
        end
        S_ZW: if (div_done) begin
          z     <= div_quot[FW-1:0];
          state <= S_XS;
        end
        S_XS: state <= S_XW;
        S_XW: if (div_done) begin
          x     <= div_sat;
          state <= S_YS;
        end
        S_YS: state <= S_YW;
        S_YW: if (div_done) begin
          y     <= div_sat;
          state <= S_UPD;
        end
        S_UPD: begin
          if (count == '0) begin
            min_x     <= x;
            max_x     <= x;
            min_y     <= y;
            max_y     <= y;
            min_z     <= z;
            max_z     <= z;
            nearest_x <= x;
            nearest_y <= y;
          end else begin
            if (x < min_x) min_x <= x;
            if (x > max_x) max_x <= x;
            if (y < min_y) min_y <= y;
            if (y > max_y) max_y <= y;
            if (z > max_z) max_z <= z;
            // strict compare keeps the earlier point on a tie
            if (z < min_z) begin
              min_z     <= z;
              nearest_x <= x;
              nearest_y <= y;
            end
          end
          count <= count + 1'b1;
          sum_x <= sum_x + drs_pkg::SUM_W'(x);
          sum_y <= sum_y + drs_pkg::SUM_W'(y);
          sum_z <= sum_z + drs_pkg::SUM_W'(z);
          state <= cur.last ? S_CXS : S_IDLE;
        end
        S_CXS: state <= S_CXW;
        S_CXW: if (div_done) begin
          cen_x <= div_quot[FW-1:0];
          state <= S_CYS;
        end
        S_CYS: state <= S_CYW;
        S_CYW: if (div_done) begin
          cen_y <= div_quot[FW-1:0];
          state <= S_CZS;
        end
        S_CZS: state <= S_CZW;
        S_CZW: if (div_done) begin
          cen_z <= div_quot[FW-1:0];
          state <= S_P0;
        end
        // plane distance: one product per cycle into a wide accumulator
        S_P0: begin
          prod  <= cfg.plane_a * $signed({1'b0, nearest_x});
          state <= S_P1;
        end
        S_P1: begin
          acc   <= 67'(prod);
          prod  <= cfg.plane_b * $signed({1'b0, nearest_y});
          state <= S_P2;
        end
        S_P2: begin
          acc   <= acc + 67'(prod);
          prod  <= cfg.plane_c * $signed({1'b0, min_z});
          state <= S_P3;
        end
        S_P3: begin
          acc   <= acc + 67'(prod);
          state <= S_PF;
        end
        S_PF: begin
          plane_dist <= dsum[drs_pkg::DIST_W-1:0];
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            found          <= (count != '0);
            centroid_x     <= (count != '0) ? cen_x : '0;
            centroid_y     <= (count != '0) ? cen_y : '0;
            centroid_z     <= (count != '0) ? cen_z : '0;
            extent_x       <= max_x - min_x;
            extent_y       <= max_y - min_y;
            extent_z       <= max_z - min_z;
            front_x        <= nearest_x;
            front_y        <= nearest_y;
            front_z        <= min_z;
            plane_distance <= (count != '0) ? $signed(plane_dist) : '0;
            count          <= '0;
            sum_x          <= '0;
            sum_y          <= '0;
            sum_z          <= '0;
            min_x          <= '0;
            max_x          <= '0;
            min_y          <= '0;
            max_y          <= '0;
            min_z          <= '0;
            max_z          <= '0;
            nearest_x      <= '0;
            nearest_y      <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/disparity_region_stats.sv =====
// Region statistics from a stream of disparity pixels. Pixels enter a
// four-entry queue at one per clock while it has room; the back end takes
// one pixel at a time. Depth, x and y of each valid point each go through
// one shared radix-2 divider with a 56-bit numerator, with a setup step
// and an update of the sums and bounds. When the region holds points, the
// pixel marked last also starts three centroid divisions on the same
// divider and the plane products before the result is loaded into the
// output register. push is refused while the queue is full.
module disparity_region_stats #(
  parameter int          COORD_MAX         = drs_pkg::COORD_MAX_DEF,
  parameter logic [32:0] MAX_REGION_PIXELS = drs_pkg::MAX_REGION_PIXELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [drs_pkg::COORD_W-1:0]          row,
  input  logic [drs_pkg::COORD_W-1:0]          col,
  input  logic [drs_pkg::DISP_W-1:0]           disparity,
  input  logic                                 last,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 found,
  output logic [drs_pkg::FIX_W-1:0]            centroid_x,
  output logic [drs_pkg::FIX_W-1:0]            centroid_y,
  output logic [drs_pkg::FIX_W-1:0]            centroid_z,
  output logic [drs_pkg::FIX_W-1:0]            extent_x,
  output logic [drs_pkg::FIX_W-1:0]            extent_y,
  output logic [drs_pkg::FIX_W-1:0]            extent_z,
  output logic [drs_pkg::FIX_W-1:0]            front_x,
  output logic [drs_pkg::FIX_W-1:0]            front_y,
  output logic [drs_pkg::FIX_W-1:0]            front_z,
  output logic signed [drs_pkg::DIST_W-1:0]    plane_distance,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [drs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [drs_pkg::FIX_W-1:0]            cfg_data
);

  logic           q_wr;
  drs_pkg::item_t q_wdata;
  logic           q_rd;
  drs_pkg::item_t q_rdata;
  logic           q_empty;
  drs_pkg::cfg_t  cfg;

  assign cfg_ready = 1'b1;

  drs_front #(.COORD_MAX(COORD_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .row      (row),
    .col      (col),
    .disparity(disparity),
    .last     (last),
    .q_wr     (q_wr),
    .q_data   (q_wdata),
    .cfg      (cfg)
  );

  drs_queue #(.DEPTH(drs_pkg::QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_data(q_wdata),
    .full   (full),
    .rd     (q_rd),
    .rd_data(q_rdata),
    .empty  (q_empty)
  );

  drs_back #(.MAX_REGION_PIXELS(MAX_REGION_PIXELS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .found         (found),
    .centroid_x    (centroid_x),
    .centroid_y    (centroid_y),
    .centroid_z    (centroid_z),
    .extent_x      (extent_x),
    .extent_y      (extent_y),
    .extent_z      (extent_z),
    .front_x       (front_x),
    .front_y       (front_y),
    .front_z       (front_z),
    .plane_distance(plane_distance)
  );

endmodule

// ===== rtl/core/drs_checker.sv =====
`include "disparity_region_stats_assert.svh"

module drs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 empty,
  input logic                                 pop,
  input logic                                 found,
  input logic [drs_pkg::FIX_W-1:0]            centroid_x,
  input logic [drs_pkg::FIX_W-1:0]            extent_x,
  input logic [drs_pkg::FIX_W-1:0]            front_z,
  input logic signed [drs_pkg::DIST_W-1:0]    plane_distance
);

  // nothing waits on the result side right after reset
  `DRS_ASSERT_NEXT(a_reset_empty, rst, empty)

  // a result not taken stays put
  `DRS_ASSERT_NEXT(a_hold, !rst && !empty && !pop, !empty && $stable(found) && $stable(front_z))

  // an empty region reports all zeros
  `DRS_ASSERT_IMPL(a_empty_zero, !empty && !found, centroid_x == '0 && extent_x == '0 && front_z == '0 && plane_distance == '0)

endmodule

bind disparity_region_stats drs_checker u_drs_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .found         (found),
  .centroid_x    (centroid_x),
  .extent_x      (extent_x),
  .front_z       (front_z),
  .plane_distance(plane_distance)
);
